// ===== hdl/timestamped_history_ring_core_defines.svh =====
// Assertion macros for the timestamped history ring
`ifndef TIMESTAMPED_HISTORY_RING_CORE_DEFINES_SVH
`define TIMESTAMPED_HISTORY_RING_CORE_DEFINES_SVH
// Assert that an antecedent implies a consequent on the next clock edge.
`define THR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that an antecedent implies a consequent in the same cycle.
`define THR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ===== hdl/thr_pkg.sv =====
// Types and constants shared by the timestamped history ring modules
package thr_pkg;
    localparam int unsigned TIME_W = 63;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned POS_W  = 6;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_CLEAR  = 3'd1;
    localparam logic [2:0] OP_LOOKUP = 3'd2;
    localparam logic [2:0] OP_LASTN  = 3'd3;
    localparam logic [2:0] OP_SINCE  = 3'd4;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [2:0]        op;
        logic [TIME_W-1:0] sample_time;
        logic [DATA_W-1:0] sample_data;
        logic [CNT_W-1:0]  max_count;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [TIME_W-1:0] out_time;
        logic [DATA_W-1:0] out_data;
        logic [POS_W-1:0]  slot_index;
        logic              last;
        logic [CNT_W-1:0]  stored_count;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input item
        logic rd_newest;  // read newest entry time
        logic push_wr;    // write pushed sample
        logic clr;        // empty the ring
        logic srch_init;  // begin binary search
        logic srch_rd;    // read time at mid
        logic srch_upd;   // narrow the interval
        logic emit_init;  // set first emitted position
        logic emit_rd;    // read entry at emit position
        logic emit_adv;   // advance emit position
        logic res_ack;    // emit an empty result
        logic res_smp;    // emit a sample result
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] op;
        logic       srch_done;
        logic       emit_none;
        logic       emit_last;
    } t_dp_sts;
endpackage

// ===== hdl/thr_ram.sv =====
// Generic single-port write, single-port registered read RAM
module thr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hdl/thr_datapath.sv =====
// Datapath: ring storage, pointers, binary search and result formatting
module thr_datapath #(
    parameter int unsigned DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  thr_pkg::t_in_item     i_item,
    input  thr_pkg::t_ctl_cmd     i_cmd,
    output thr_pkg::t_dp_sts      o_sts,
    output logic                  o_valid,
    output thr_pkg::t_out_item    o_res
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = thr_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    thr_pkg::t_in_item      r_item;
    logic [AW-1:0]          r_oldest;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_lo, r_hi, r_pos;
    logic [CW-1:0]          r_raddr_mid, r_emit_pos;
    logic                   r_valid;
    thr_pkg::t_out_item     r_res;
    logic [thr_pkg::TIME_W-1:0] w_rtime;
    logic [thr_pkg::DATA_W-1:0] w_rdata;
    logic [CW-1:0]          w_mid, w_avail, w_n, w_first, w_rdpos;
    logic [CW-1:0]          w_count_nx;
    logic [AW-1:0]          w_raddr, w_waddr;
    logic [thr_pkg::TIME_W-1:0] w_ptime;
    logic                   w_full;

    // Position to physical slot, wrapping at DEPTH
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] pos);
        logic [CW:0] s;
        s = {1'b0, {(CW-AW){1'b0}}, base} + {1'b0, pos};
        if (s >= (CW+1)'(DEPTH)) begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign w_mid  = CW'((r_lo + r_hi) >> 1);
    assign w_full = (r_count >= DEPTH_C);

    always_comb begin
        w_rdpos = r_count - CW'(1);
        if (i_cmd.srch_rd) begin
            w_rdpos = w_mid;
        end else if (i_cmd.emit_rd) begin
            w_rdpos = r_pos;
        end
    end
    assign w_raddr = phys(r_oldest, w_rdpos);
    assign w_waddr = w_full ? r_oldest : phys(r_oldest, r_count);

    always_comb begin
        w_ptime = r_item.sample_time;
        if (r_count != '0 && r_item.sample_time <= w_rtime) begin
            w_ptime = (w_rtime == thr_pkg::TIME_MAX) ? thr_pkg::TIME_MAX
                                                     : w_rtime + 1'b1;
        end
    end

    // Count held after this step, reported with the result
    always_comb begin
        w_count_nx = r_count;
        if (i_cmd.clr) begin
            w_count_nx = '0;
        end else if (i_cmd.push_wr && !w_full) begin
            w_count_nx = r_count + 1'b1;
        end
    end

    thr_ram #(.WIDTH(thr_pkg::TIME_W), .DEPTH(DEPTH)) u_time (
        .i_clk(i_clk), .i_we(i_cmd.push_wr), .i_waddr(w_waddr), .i_wdata(w_ptime),
        .i_raddr(w_raddr), .o_rdata(w_rtime)
    );
    thr_ram #(.WIDTH(thr_pkg::DATA_W), .DEPTH(DEPTH)) u_data (
        .i_clk(i_clk), .i_we(i_cmd.push_wr), .i_waddr(w_waddr),
        .i_wdata(r_item.sample_data), .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    // Emit start: lo holds the search count for read-since and lookup;
    // a lookup with no match wraps below zero and reads as nothing to emit
    always_comb begin
        w_avail = (r_item.op == thr_pkg::OP_LASTN) ? r_count : r_count - r_lo;
        w_n     = (r_item.max_count != '0 && r_item.max_count < w_avail)
                  ? r_item.max_count : w_avail;
        w_first = (r_item.op == thr_pkg::OP_LOOKUP) ? r_lo - CW'(1) : r_count - w_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_ack | i_cmd.res_smp;
            if (i_cmd.clr) begin
                r_oldest <= '0;
                r_count  <= '0;
            end else if (i_cmd.push_wr) begin
                if (w_full) begin
                    r_oldest <= (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.srch_upd) begin
            if (w_rtime <= r_item.sample_time) begin
                r_lo <= r_raddr_mid + 1'b1;
            end else begin
                r_hi <= r_raddr_mid;
            end
        end
        if (i_cmd.srch_rd) begin
            r_raddr_mid <= w_mid;
        end
        if (i_cmd.emit_init) begin
            r_pos <= w_first;
        end else if (i_cmd.emit_adv) begin
            r_pos <= r_pos + 1'b1;
        end
        if (i_cmd.emit_rd) begin
            r_emit_pos <= r_pos;
        end
        r_res.found        <= i_cmd.res_smp;
        r_res.stored_count <= w_count_nx;
        if (i_cmd.res_smp) begin
            r_res.out_time   <= w_rtime;
            r_res.out_data   <= w_rdata;
            r_res.slot_index <= r_emit_pos[thr_pkg::POS_W-1:0];
            r_res.last       <= (r_item.op == thr_pkg::OP_LOOKUP)
                                || (r_emit_pos == r_count - CW'(1));
        end else begin
            r_res.out_time   <= '0;
            r_res.out_data   <= '0;
            r_res.slot_index <= '0;
            r_res.last       <= 1'b1;
        end
    end

    assign o_sts.op        = r_item.op;
    assign o_sts.srch_done = (r_lo >= r_hi);
    assign o_sts.emit_none = (w_first >= r_count);
    assign o_sts.emit_last = (r_pos == r_count - CW'(1));
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

// ===== hdl/thr_controller.sv =====
// Controller: sequences push, clear, search and streaming reads
module thr_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  thr_pkg::t_dp_sts  i_sts,
    output thr_pkg::t_ctl_cmd o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DEC    = 9'b000000010,
        S_PUSHRD = 9'b000000100,
        S_PUSHWR = 9'b000001000,
        S_SRCH   = 9'b000010000,
        S_SWAIT  = 9'b000100000,
        S_EINIT  = 9'b001000000,
        S_ERD    = 9'b010000000,
        S_EOUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.op)
                    thr_pkg::OP_PUSH: begin
                        o_cmd.rd_newest = 1'b1;
                        n_state = S_PUSHWR;
                    end
                    thr_pkg::OP_CLEAR: begin
                        o_cmd.clr = 1'b1;
                        o_cmd.res_ack = 1'b1;
                        n_state = S_IDLE;
                    end
                    thr_pkg::OP_LOOKUP, thr_pkg::OP_SINCE: begin
                        o_cmd.srch_init = 1'b1;
                        n_state = S_SRCH;
                    end
                    thr_pkg::OP_LASTN: begin
                        n_state = S_EINIT;
                    end
                    default: begin
                        o_cmd.res_ack = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_PUSHRD: begin
                n_state = S_PUSHWR;
            end
            S_PUSHWR: begin
                o_cmd.push_wr = 1'b1;
                o_cmd.res_ack = 1'b1;
                n_state = S_IDLE;
            end
            S_SRCH: begin
                if (i_sts.srch_done) begin
                    if (i_sts.op == thr_pkg::OP_LOOKUP) begin
                        o_cmd.emit_init = 1'b1;
                    end
                    n_state = S_EINIT;
                end else begin
                    o_cmd.srch_rd = 1'b1;
                    n_state = S_SWAIT;
                end
            end
            S_SWAIT: begin
                o_cmd.srch_upd = 1'b1;
                n_state = S_SRCH;
            end
            S_EINIT: begin
                o_cmd.emit_init = 1'b1;
                n_state = S_ERD;
            end
            S_ERD: begin
                if (i_sts.emit_none) begin
                    o_cmd.res_ack = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.emit_rd = 1'b1;
                    n_state = S_EOUT;
                end
            end
            S_EOUT: begin
                o_cmd.res_smp = 1'b1;
                o_cmd.emit_adv = 1'b1;
                n_state = (i_sts.emit_last || i_sts.op == thr_pkg::OP_LOOKUP) ? S_IDLE : S_ERD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== hdl/timestamped_history_ring_core.sv =====
// Top level of the timestamped history ring
// Sequence after acceptance: push reads the newest time, then writes; clear and unknown op
// answer from decode; read-last-n streams from EINIT, lookup and read-since first run a binary
// search of k steps, k = ceil(log2(count + 1)), at most 7; a read that finds nothing answers
// from ERD with an empty result. One item at a time; reads alternate ERD and EOUT per result
// (shared read port); busy falls as the last result appears. Reset (sync, active low) empties the ring; no stall.
module timestamped_history_ring_core #(
    parameter int unsigned DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  thr_pkg::t_in_item  i_item,
    output logic               o_valid,
    output thr_pkg::t_out_item o_res
);
    thr_pkg::t_ctl_cmd w_cmd;
    thr_pkg::t_dp_sts  w_sts;

    // Sequence each item through its states
    thr_controller u_ctl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    // Hold the ring and format results
    thr_datapath #(.DEPTH(DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_valid(o_valid), .o_res(o_res)
    );
endmodule

// ===== hdl/thr_checker.sv =====
// Port-level checker for the timestamped history ring, with its bind
`include "timestamped_history_ring_core_defines.svh"
module thr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input thr_pkg::t_out_item o_res
);
    `THR_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `THR_ASSERT_SAME(a_count_range, i_clk, i_rst_n, o_valid, o_res.stored_count <= 7'd64, "count")
    `THR_ASSERT_SAME(a_empty_nf, i_clk, i_rst_n, o_valid && !o_res.found, o_res.last, "last")
endmodule

bind timestamped_history_ring_core thr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_res(o_res)
);
